### hw/rtl/dd_pkg.sv
// shared types, constants and calendar tables for the date difference block
`default_nettype none

package dd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int DAYS_W  = 22;
  // day number of any 14-bit year fits in 23 bits
  localparam int DN_W    = 23;
  localparam int MOFF_W  = 9;
  localparam int MP_W    = 5;

  localparam int unsigned MAX_YEAR_DEF = 9999;

  localparam logic [DAYS_W-1:0] DAYS_MAX = {DAYS_W{1'b1}};

  // floor(x/100) = (x * 5243) >> 19, exact for all 14-bit x
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int Q_W         = PROD_W - RECIP_SHIFT;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // register stages from accepted beat to result strobe
  localparam int PIPE_LAT = 4;

  typedef struct packed {
    logic [YEAR_W-1:0] year_a;
    logic [MON_W-1:0]  month_a;
    logic [DAY_W-1:0]  day_a;
    logic [YEAR_W-1:0] year_b;
    logic [MON_W-1:0]  month_b;
    logic [DAY_W-1:0]  day_b;
  } in_t;

  typedef struct packed {
    logic [DAYS_W-1:0] days_between;
    logic              bad_date;
  } out_t;

  typedef struct packed {
    logic [DN_W-1:0] dn;
    logic            ok;
  } daynum_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the shifted month, year starting in march: (153*mp+2)/5
  function automatic logic [MOFF_W-1:0] month_offset(input logic [MP_W-1:0] mp);
    logic [MOFF_W-1:0] off;
    case (mp)
      5'd0:    off = 9'd0;
      5'd1:    off = 9'd31;
      5'd2:    off = 9'd61;
      5'd3:    off = 9'd92;
      5'd4:    off = 9'd122;
      5'd5:    off = 9'd153;
      5'd6:    off = 9'd184;
      5'd7:    off = 9'd214;
      5'd8:    off = 9'd245;
      5'd9:    off = 9'd275;
      5'd10:   off = 9'd306;
      5'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dd_daynum.sv
// three-stage pipeline turning one date into a day number and a validity flag
`default_nettype none

module dd_daynum #(
  parameter int unsigned MAX_YEAR = dd_pkg::MAX_YEAR_DEF
) (
  input  wire logic                       clk,
  input  wire logic [dd_pkg::YEAR_W-1:0]  year,
  input  wire logic [dd_pkg::MON_W-1:0]   month,
  input  wire logic [dd_pkg::DAY_W-1:0]   day,
  output dd_pkg::daynum_t                 result
);

  localparam int YW = dd_pkg::YEAR_W;
  localparam int DW = dd_pkg::DN_W;
  localparam int PW = dd_pkg::PROD_W;
  localparam int QW = dd_pkg::Q_W;
  localparam int MW = dd_pkg::MOFF_W;

  // stage a: reciprocal products and range checks
  logic [YW-1:0]             yy;
  logic [dd_pkg::MP_W-1:0]   mp;
  logic [PW-1:0]             prod_y_nxt, prod_yy_nxt;
  logic                      yok_nxt, mok_nxt;

  logic [PW-1:0]             prod_y_r, prod_yy_r;
  logic [YW-1:0]             y_r, yy_r;
  logic [dd_pkg::MP_W-1:0]   mp_r;
  logic [dd_pkg::MON_W-1:0]  m_r;
  logic [dd_pkg::DAY_W-1:0]  d_r;
  logic                      yok_r, mok_r;

  always_comb begin
    // january and february count as months of the previous year
    yy = (month <= dd_pkg::MON_FEB) ? YW'(year - YW'(1)) : year;
    mp = (month > dd_pkg::MON_FEB) ? dd_pkg::MP_W'(month) - 5'd3
                                    : dd_pkg::MP_W'(month) + 5'd9;
    prod_y_nxt  = PW'(year) * PW'(dd_pkg::RECIP_100);
    prod_yy_nxt = PW'(yy) * PW'(dd_pkg::RECIP_100);
    yok_nxt = (year != '0) && (32'(year) <= 32'(MAX_YEAR));
    mok_nxt = (month >= dd_pkg::MON_JAN) && (month <= dd_pkg::MON_DEC);
  end

  always_ff @(posedge clk) begin
    prod_y_r  <= prod_y_nxt;
    prod_yy_r <= prod_yy_nxt;
    y_r       <= year;
    yy_r      <= yy;
    mp_r      <= mp;
    m_r       <= month;
    d_r       <= day;
    yok_r     <= yok_nxt;
    mok_r     <= mok_nxt;
  end

  // stage b: leap year, day check, year part and month part of the day number
  logic [QW-1:0]             q_y, q_yy;
  logic [YW-1:0]             r_y;
  logic                      leap;
  logic [dd_pkg::DAY_W-1:0]  lim;
  logic                      ok_b_nxt;
  logic [DW-1:0]             base_nxt;
  logic [MW-1:0]             moff_nxt;

  logic                      ok_b_r;
  logic [DW-1:0]             base_r;
  logic [MW-1:0]             moff_r;

  always_comb begin
    q_y  = prod_y_r[PW-1:dd_pkg::RECIP_SHIFT];
    q_yy = prod_yy_r[PW-1:dd_pkg::RECIP_SHIFT];
    r_y  = YW'(y_r - YW'(q_y) * YW'(100));
    leap = ((r_y == '0) && (q_y[1:0] == 2'b00)) ||
           ((r_y != '0) && (y_r[1:0] == 2'b00));
    lim  = dd_pkg::month_len(m_r, leap);
    ok_b_nxt = yok_r && mok_r && (d_r != '0) && (d_r <= lim);
    base_nxt = DW'(yy_r) * DW'(365) + DW'(yy_r >> 2) - DW'(q_yy) + DW'(q_yy >> 2);
    moff_nxt = dd_pkg::month_offset(mp_r) + MW'(d_r) - MW'(1);
  end

  always_ff @(posedge clk) begin
    ok_b_r <= ok_b_nxt;
    base_r <= base_nxt;
    moff_r <= moff_nxt;
  end

  // stage c: final sum
  logic [DW-1:0] dn_r;
  logic          ok_c_r;

  always_ff @(posedge clk) begin
    dn_r   <= base_r + DW'(moff_r);
    ok_c_r <= ok_b_r;
  end

  assign result = '{dn: dn_r, ok: ok_c_r};

endmodule

`default_nettype wire

### hw/rtl/dd_absdiff.sv
// final stage: absolute difference of two day numbers with saturation and error zeroing
`default_nettype none

module dd_absdiff (
  input  wire logic            clk,
  input  wire dd_pkg::daynum_t a,
  input  wire dd_pkg::daynum_t b,
  output dd_pkg::out_t         result
);

  localparam int DW = dd_pkg::DN_W;

  logic [DW-1:0]   diff;
  dd_pkg::out_t    result_nxt;
  dd_pkg::out_t    result_r;

  always_comb begin
    diff = (a.dn >= b.dn) ? DW'(a.dn - b.dn) : DW'(b.dn - a.dn);
    result_nxt.bad_date = !(a.ok && b.ok);
    if (result_nxt.bad_date) begin
      result_nxt.days_between = '0;
    end else if (diff > DW'(dd_pkg::DAYS_MAX)) begin
      result_nxt.days_between = dd_pkg::DAYS_MAX;
    end else begin
      result_nxt.days_between = diff[dd_pkg::DAYS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign result = result_r;

endmodule

`default_nettype wire

### hw/rtl/date_difference_days_top.sv
// top level: gregorian date difference in days, four-stage pipeline
`default_nettype none

// Takes one pair of dates per clock: a beat is accepted whenever start is high,
// since busy is held low at all times. Each accepted beat yields exactly one
// result, shown for one cycle with out_valid high; the receiver must take it
// then. The pipeline holds a reciprocal multiply stage, a leap-year and
// day-number stage, a summing stage and a difference stage. Results leave in
// the order the beats came in. A month or day out of range, or a year of zero
// or above MAX_YEAR, gives bad_date high with a zero day count; a difference
// too wide for 22 bits saturates.
module date_difference_days_top #(
  parameter int unsigned MAX_YEAR = dd_pkg::MAX_YEAR_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire dd_pkg::in_t in_data,
  output logic             out_valid,
  output dd_pkg::out_t     out_data
);

  localparam int LAT = dd_pkg::PIPE_LAT;

  logic           accept;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  dd_pkg::daynum_t dn_a, dn_b;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits ride alongside the data stages
  assign vld_nxt = {vld_r[LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  dd_daynum #(.MAX_YEAR(MAX_YEAR)) u_daynum_a (
    .clk    (clk),
    .year   (in_data.year_a),
    .month  (in_data.month_a),
    .day    (in_data.day_a),
    .result (dn_a)
  );

  dd_daynum #(.MAX_YEAR(MAX_YEAR)) u_daynum_b (
    .clk    (clk),
    .year   (in_data.year_b),
    .month  (in_data.month_b),
    .day    (in_data.day_b),
    .result (dn_b)
  );

  dd_absdiff u_absdiff (
    .clk    (clk),
    .a      (dn_a),
    .b      (dn_b),
    .result (out_data)
  );

  assign out_valid = vld_r[LAT-1];

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bad_date |-> out_data.days_between == '0)
    else $error("bad date result carries a nonzero count");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted beat did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result strobe without a matching accepted beat");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

`default_nettype wire

### tb/date_difference_days_top_test.sv
// testbench for the gregorian date difference block: directed and random date pairs
`default_nettype none

module date_difference_days_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_YEAR = dd_pkg::MAX_YEAR_DEF;
  localparam int unsigned YEAR_TOP = (1 << dd_pkg::YEAR_W) - 1;
  localparam int unsigned DAYS_SAT = (1 << dd_pkg::DAYS_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  dd_pkg::in_t  in_data = '0;
  logic out_valid;
  dd_pkg::out_t out_data;

  dd_pkg::out_t pending_gaps[$];
  int unsigned mismatch_count = 0;
  bit gaps_on = 1'b1;

  date_difference_days_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= days_in_month(y, m));
  endfunction

  // days since 0000-03-01, year taken to start in march
  function automatic int unsigned epoch_day(int unsigned y, int unsigned m, int unsigned d);
    int unsigned ye;
    int unsigned mp;
    ye = (m <= 2) ? y - 1 : y;
    mp = (m > 2) ? m - 3 : m + 9;
    return 365 * ye + ye / 4 - ye / 100 + ye / 400 + (153 * mp + 2) / 5 + d - 1;
  endfunction

  function automatic dd_pkg::out_t expected_gap(dd_pkg::in_t p);
    dd_pkg::out_t r;
    int unsigned na;
    int unsigned nb;
    int unsigned diff;
    r = '0;
    if (!date_valid(p.year_a, p.month_a, p.day_a) ||
        !date_valid(p.year_b, p.month_b, p.day_b)) begin
      r.bad_date = 1'b1;
      return r;
    end
    na = epoch_day(p.year_a, p.month_a, p.day_a);
    nb = epoch_day(p.year_b, p.month_b, p.day_b);
    diff = (na >= nb) ? na - nb : nb - na;
    if (diff > DAYS_SAT) diff = DAYS_SAT;
    r.days_between = diff[dd_pkg::DAYS_W-1:0];
    return r;
  endfunction

  function automatic dd_pkg::in_t make_pair(int unsigned ya, int unsigned ma,
                                            int unsigned da, int unsigned yb,
                                            int unsigned mb, int unsigned db);
    dd_pkg::in_t p;
    p.year_a  = ya[dd_pkg::YEAR_W-1:0];
    p.month_a = ma[dd_pkg::MON_W-1:0];
    p.day_a   = da[dd_pkg::DAY_W-1:0];
    p.year_b  = yb[dd_pkg::YEAR_W-1:0];
    p.month_b = mb[dd_pkg::MON_W-1:0];
    p.day_b   = db[dd_pkg::DAY_W-1:0];
    return p;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic send_date_pair(dd_pkg::in_t pair);
    if (gaps_on && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= pair;
    do @(posedge clk); while (busy !== 1'b0);
    pending_gaps.push_back(expected_gap(pair));
  endtask

  always @(posedge clk) begin
    dd_pkg::out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_gaps.size() == 0) begin
        report_mismatch("result with no pair outstanding", out_data.days_between, 0);
      end else begin
        want = pending_gaps.pop_front();
        if (out_data.days_between !== want.days_between)
          report_mismatch("days_between", out_data.days_between, want.days_between);
        if (out_data.bad_date !== want.bad_date)
          report_mismatch("bad_date", out_data.bad_date, want.bad_date);
      end
    end
  end

  task automatic pick_date(output int unsigned y, output int unsigned m, output int unsigned d);
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1, 3);
      1:       y = $urandom_range(MAX_YEAR - 2, MAX_YEAR);
      2:       y = 400 * $urandom_range(1, MAX_YEAR / 400);
      3:       y = 100 * $urandom_range(1, MAX_YEAR / 100);
      default: y = $urandom_range(1, MAX_YEAR);
    endcase
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 3) == 0) ? days_in_month(y, m)
                                    : $urandom_range(1, days_in_month(y, m));
  endtask

  // push one field of a valid date out of its range
  task automatic break_date(inout int unsigned y, inout int unsigned m, inout int unsigned d);
    int unsigned len;
    len = days_in_month(y, m);
    case ($urandom_range(0, 3))
      0: m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15);
      1: d = 0;
      2: d = (len < 31) ? $urandom_range(len + 1, 31) : 0;
      default: y = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_YEAR + 1, YEAR_TOP);
    endcase
  endtask

  task automatic test_directed();
    send_date_pair(make_pair(1, 1, 1, MAX_YEAR, 12, 31));
    send_date_pair(make_pair(MAX_YEAR, 12, 31, 1, 1, 1));
    send_date_pair(make_pair(2024, 6, 15, 2024, 6, 15));
    send_date_pair(make_pair(2000, 2, 29, 2000, 3, 1));
    send_date_pair(make_pair(1900, 2, 29, 1900, 3, 1));
    send_date_pair(make_pair(2004, 2, 29, 2003, 2, 28));
    send_date_pair(make_pair(2001, 2, 29, 2001, 1, 1));
    send_date_pair(make_pair(2023, 0, 10, 2023, 5, 5));
    send_date_pair(make_pair(2023, 13, 1, 2023, 5, 5));
    send_date_pair(make_pair(2023, 5, 5, 2023, 15, 31));
    send_date_pair(make_pair(2023, 4, 0, 2023, 4, 1));
    send_date_pair(make_pair(2023, 4, 31, 2023, 4, 1));
    send_date_pair(make_pair(0, 1, 1, 5, 1, 1));
    send_date_pair(make_pair(MAX_YEAR + 1, 1, 1, 5, 1, 1));
    send_date_pair(make_pair(YEAR_TOP, 15, 31, YEAR_TOP, 15, 31));
    send_date_pair(make_pair(0, 0, 0, 0, 0, 0));
    send_date_pair(make_pair(1, 12, 31, 2, 1, 1));
    send_date_pair(make_pair(MAX_YEAR, 1, 31, MAX_YEAR, 2, 28));
    send_date_pair(make_pair(1600, 2, 29, 2400, 2, 29));
    send_date_pair(make_pair(4, 2, 29, 1, 1, 1));
    send_date_pair(make_pair(MAX_YEAR, 12, 31, MAX_YEAR, 12, 31));
    send_date_pair(make_pair(2023, 12, 31, 2023, 11, 31));
  endtask

  // mostly well-formed dates, a tenth of them with one field broken
  task automatic test_random_dates(int unsigned count);
    int unsigned ya, ma, da, yb, mb, db;
    repeat (count) begin
      pick_date(ya, ma, da);
      if ($urandom_range(0, 7) == 0) begin
        yb = ya;
        mb = ma;
        db = $urandom_range(1, days_in_month(yb, mb));
      end else begin
        pick_date(yb, mb, db);
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) == 0) break_date(ya, ma, da);
        else break_date(yb, mb, db);
      end
      send_date_pair(make_pair(ya, ma, da, yb, mb, db));
    end
  endtask

  task automatic test_raw_fields(int unsigned count);
    repeat (count) begin
      send_date_pair(make_pair($urandom_range(0, YEAR_TOP), $urandom_range(0, 15),
                               $urandom_range(0, 31), $urandom_range(0, YEAR_TOP),
                               $urandom_range(0, 15), $urandom_range(0, 31)));
    end
  endtask

  task automatic test_back_to_back(int unsigned count);
    gaps_on = 1'b0;
    test_random_dates(count);
    gaps_on = 1'b1;
  endtask

  initial begin
    int unsigned drain;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_dates(750);
    test_back_to_back(250);
    test_raw_fields(230);

    start <= 1'b0;
    drain = 0;
    while (pending_gaps.size() != 0 && drain < 100) begin
      @(posedge clk);
      drain++;
    end
    repeat (dd_pkg::PIPE_LAT + 4) @(posedge clk);
    if (pending_gaps.size() != 0)
      report_mismatch("results never arrived", 0, pending_gaps.size());

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/dd_pkg.sv
hw/rtl/dd_daynum.sv
hw/rtl/dd_absdiff.sv
hw/rtl/date_difference_days_top.sv
tb/date_difference_days_top_test.sv
